// File: hdl/spg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants of the Sobol' point generator.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DIM_W      = 3;
  localparam int unsigned COL_W      = 5;
  localparam int unsigned NBITS_W    = 6;
  localparam int unsigned NDIMS_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_DIR   = 2'd0,
    MODE_LOAD_SHIFT = 2'd1,
    MODE_GEN        = 2'd2
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_ORDER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ENABLE = 3'd4;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

endpackage

// File: hdl/spg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_in_if
// Input item channel: loads and point requests.
// ----------------------------------------------------------------------------
interface spg_in_if import spg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [DIM_W-1:0]    dim;
  logic [COL_W-1:0]    bit_index;
  logic [WORD_W-1:0]   load_value;
  logic [WORD_W-1:0]   point_index;

  modport source (output valid, mode, dim, bit_index, load_value, point_index,
                  input ready);
  modport sink   (input valid, mode, dim, bit_index, load_value, point_index,
                  output ready);
endinterface

// File: hdl/spg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_out_if
// Result channel: one coordinate per dimension.
// ----------------------------------------------------------------------------
interface spg_out_if import spg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIM_W-1:0]  out_dim;
  logic [WORD_W-1:0] coordinate;
  logic              last;

  modport source (output valid, out_dim, coordinate, last, input ready);
  modport sink   (input valid, out_dim, coordinate, last, output ready);
endinterface

// File: hdl/spg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface spg_cfg_if import spg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/spg_dir_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_dir_mem
// Direction-number table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spg_dir_mem import spg_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/spg_shift_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_shift_mem
// Digital-shift table, one word per dimension, reads zero until written.
// ----------------------------------------------------------------------------
module spg_shift_mem import spg_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DEPTH-1:0]  valid_d;
  logic [WORD_W-1:0] rdata_q;

  always_comb begin
    valid_d = valid_q;
    if (we_i) begin
      valid_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/spg_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_accum
// Shared XOR accumulator with bit-reversal and digital-shift finish.
// ----------------------------------------------------------------------------
module spg_accum import spg_pkg::*; (
  input  logic               clk_i,
  input  acc_ctrl_t          ctrl_i,
  input  logic [WORD_W-1:0]  rd_data_i,
  input  logic [WORD_W-1:0]  shift_word_i,
  input  logic [NBITS_W-1:0] nb_i,
  input  logic               msb_first_i,
  input  logic               shift_en_i,
  output logic [WORD_W-1:0]  coord_o
);

  logic [WORD_W-1:0]  acc_q;
  logic [WORD_W-1:0]  acc_d;
  logic [WORD_W-1:0]  rev;
  logic [WORD_W-1:0]  rev_low;
  logic [NBITS_W-1:0] shamt;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = acc_q ^ rd_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      rev[k] = acc_q[WORD_W-1-k];
    end
  end

  // reverse over the low nb bits: full reversal, then drop the spare bits
  assign shamt   = NBITS_W'(WORD_W) - nb_i;
  assign rev_low = rev >> shamt;

  assign coord_o = (msb_first_i ? acc_q : rev_low) ^ (shift_en_i ? shift_word_i : '0);

endmodule

// File: hdl/sobol_point_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_point_generator_core
// Sobol' point generator with optional per-dimension digital shift.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : mode 0 loads a direction number (dim, bit_index, load_value),
//            mode 1 loads a shift word (dim, load_value), mode 2 generates
//            the point at point_index.
//   out_if : one coordinate per dimension in use, in dimension order,
//            last set on the final one.
//   cfg_if : register writes, always ready; write only while idle.
//   Each dimension walks nb direction columns through the single read port
//   of the direction memory, one column per cycle (nd dimensions, nb bits
//   in use). in_if is not ready while a point is walked.
//   A finished coordinate sits in an output register; when the receiver
//   stalls with it full the walk holds until the transfer happens. The
//   next item may be accepted while the last coordinate still waits.
//   Reset loads the register defaults and clears the shift table; the
//   direction table holds garbage until loaded.
// ----------------------------------------------------------------------------
module sobol_point_generator_core import spg_pkg::*; #(
  parameter int unsigned MAX_DIMS = 8,
  parameter int unsigned MAX_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  spg_in_if.sink    in_if,
  spg_out_if.source out_if,
  spg_cfg_if.sink   cfg_if
);

  localparam int unsigned DirDepth = MAX_DIMS * MAX_BITS;
  localparam int unsigned DirAw    = (DirDepth > 1) ? $clog2(DirDepth) : 1;
  localparam int unsigned ShAw     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned NdW      = $clog2(MAX_DIMS + 1);
  localparam int unsigned BitCap   = (MAX_BITS < 32) ? MAX_BITS : 32;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // configuration
  logic [NDIMS_W-1:0] dims_q;
  logic [NBITS_W-1:0] bits_q;
  logic               gray_q;
  logic               msb_first_q;
  logic               shift_en_q;

  // sequencer
  logic [1:0]         state_q, state_d;
  logic [WORD_W-1:0]  idx_q, idx_d;
  logic [NdW-1:0]     nd_q, nd_d;
  logic [NBITS_W-1:0] nb_q, nb_d;
  logic [ShAw-1:0]    j_q, j_d;
  logic [COL_W-1:0]   m_q, m_d;
  logic [DirAw-1:0]   base_q, base_d;
  logic               rd_v_q, rd_v_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [DIM_W-1:0]   out_dim_q, out_dim_d;
  logic [WORD_W-1:0]  coord_q, coord_d;
  logic               last_q, last_d;

  logic               in_fire;
  logic               dir_we;
  logic [DirAw-1:0]   dir_waddr;
  logic               sh_we;
  logic [WORD_W-1:0]  dir_rdata;
  logic [WORD_W-1:0]  sh_rdata;
  logic [WORD_W-1:0]  coord;
  logic               dim_ok;
  logic               col_ok;
  logic               last_dim;
  logic               out_load;
  logic               m_end;
  logic [31:0]        nd_sat;
  logic [31:0]        nb_sat;
  mode_e              mode;
  acc_ctrl_t          acc_ctrl;

  // ---------------------------------------------------------------- config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q      <= NDIMS_W'(1);
      bits_q      <= NBITS_W'(32);
      gray_q      <= 1'b0;
      msb_first_q <= 1'b1;
      shift_en_q  <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_DIMS_IN_USE:  dims_q      <= cfg_if.data[NDIMS_W-1:0];
        CFG_BITS_IN_USE:  bits_q      <= cfg_if.data[NBITS_W-1:0];
        CFG_GRAY_ORDER:   gray_q      <= cfg_if.data[0];
        CFG_MSB_FIRST:    msb_first_q <= cfg_if.data[0];
        CFG_SHIFT_ENABLE: shift_en_q  <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------------- loads
  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign mode        = mode_e'(in_if.mode);

  assign dim_ok    = (32'(in_if.dim) < MAX_DIMS);
  assign col_ok    = (32'(in_if.bit_index) < MAX_BITS);
  assign dir_we    = in_fire && (mode == MODE_LOAD_DIR) && dim_ok && col_ok;
  assign sh_we     = in_fire && (mode == MODE_LOAD_SHIFT) && dim_ok;
  assign dir_waddr = DirAw'(32'(in_if.dim) * MAX_BITS + 32'(in_if.bit_index));

  spg_dir_mem #(
    .DEPTH (DirDepth),
    .AW    (DirAw)
  ) u_dir_mem (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (in_if.load_value),
    .raddr_i (base_q + DirAw'(m_q)),
    .rdata_o (dir_rdata)
  );

  spg_shift_mem #(
    .DEPTH (MAX_DIMS),
    .AW    (ShAw)
  ) u_shift_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (sh_we),
    .waddr_i (ShAw'(in_if.dim)),
    .wdata_i (in_if.load_value),
    .raddr_i (j_q),
    .rdata_o (sh_rdata)
  );

  spg_accum u_accum (
    .clk_i        (clk_i),
    .ctrl_i       (acc_ctrl),
    .rd_data_i    (dir_rdata),
    .shift_word_i (sh_rdata),
    .nb_i         (nb_q),
    .msb_first_i  (msb_first_q),
    .shift_en_i   (shift_en_q),
    .coord_o      (coord)
  );

  // ------------------------------------------------------------- sequencer
  assign nd_sat = (dims_q == '0) ? 32'd1 :
                  ((32'(dims_q) > MAX_DIMS) ? MAX_DIMS : 32'(dims_q));
  assign nb_sat = (bits_q == '0) ? 32'd1 :
                  ((32'(bits_q) > BitCap) ? BitCap : 32'(bits_q));

  assign m_end    = ({1'b0, m_q} == (nb_q - NBITS_W'(1)));
  assign last_dim = ((NdW'(j_q) + NdW'(1)) == nd_q);
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_if.ready);

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    nd_d           = nd_q;
    nb_d           = nb_q;
    j_d            = j_q;
    m_d            = m_q;
    base_d         = base_q;
    acc_ctrl.clear = 1'b0;
    acc_ctrl.add   = rd_v_q;
    rd_v_d         = (state_q == S_READ) && idx_q[m_q];

    case (state_q)
      S_IDLE: begin
        if (in_fire && (mode == MODE_GEN)) begin
          idx_d          = gray_q ? (in_if.point_index ^ (in_if.point_index >> 1))
                                  : in_if.point_index;
          nd_d           = NdW'(nd_sat);
          nb_d           = NBITS_W'(nb_sat);
          j_d            = '0;
          m_d            = '0;
          base_d         = '0;
          acc_ctrl.clear = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        if (m_end) begin
          state_d = S_LAST;
        end else begin
          m_d = m_q + COL_W'(1);
        end
      end
      S_LAST: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          if (last_dim) begin
            state_d = S_IDLE;
          end else begin
            j_d            = j_q + ShAw'(1);
            m_d            = '0;
            base_d         = base_q + DirAw'(MAX_BITS);
            acc_ctrl.clear = 1'b1;
            state_d        = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nd_q    <= NdW'(1);
      nb_q    <= NBITS_W'(1);
      j_q     <= '0;
      m_q     <= '0;
      base_q  <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      nd_q    <= nd_d;
      nb_q    <= nb_d;
      j_q     <= j_d;
      m_q     <= m_d;
      base_q  <= base_d;
      rd_v_q  <= rd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // --------------------------------------------------------------- output
  always_comb begin
    out_valid_d = out_valid_q;
    out_dim_d   = out_dim_q;
    coord_d     = coord_q;
    last_d      = last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_dim_d   = DIM_W'(j_q);
      coord_d     = coord;
      last_d      = last_dim;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dim_q <= out_dim_d;
    coord_q   <= coord_d;
    last_q    <= last_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_dim    = out_dim_q;
  assign out_if.coordinate = coord_q;
  assign out_if.last       = last_q;

  // ------------------------------------------------------------ assertions
  a_gen_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (mode == MODE_GEN)) |=>
      (state_q == S_READ) && (j_q == '0) && (m_q == '0))
    else $error("point walk did not start at dimension 0, column 0");

  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (NdW'(j_q) < nd_q))
    else $error("dimension counter ran past dimensions in use");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ({1'b0, m_q} < nb_q))
    else $error("column counter ran past bits in use");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_dim) |=> (state_q == S_IDLE) && out_valid_q && last_q)
    else $error("final coordinate did not end the point");

endmodule

// File: tb/sv/sobol_point_generator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_point_generator_core_test
// Self-checking bench for the Sobol' point generator core.
// The direction table is filled first, then the run steps through a series of
// register settings (defaults, extremes, out-of-range counts, random ones).
// The fixed settings get a few directed requests; each setting gets a random mix
// of load bursts followed by point requests, with idle gaps on both channels. A
// tracker mirrors the tables and registers and checks every coordinate in order.
// ----------------------------------------------------------------------------

localparam int unsigned SPG_DIMS = 8;
localparam int unsigned SPG_COLS = 32;

typedef struct packed {
  logic [1:0]  mode;
  logic [2:0]  dim;
  logic [4:0]  bit_index;
  logic [31:0] load_value;
  logic [31:0] point_index;
} spg_request_t;

typedef struct packed {
  logic [2:0]  out_dim;
  logic [31:0] coordinate;
  logic        last;
} spg_coord_t;

typedef struct packed {
  logic [3:0] dims;
  logic [5:0] bits;
  logic       gray;
  logic       msb;
  logic       shift;
} spg_setting_t;

class sobol_tracker;
  logic [31:0]  dir_words [SPG_DIMS][SPG_COLS];
  logic [31:0]  shift_words [SPG_DIMS];
  logic [3:0]   dims_reg;
  logic [5:0]   bits_reg;
  logic         gray_reg;
  logic         msb_reg;
  logic         shift_reg;
  spg_coord_t   pending_coords[$];
  int unsigned  mismatches;
  int unsigned  points;
  int unsigned  coords_checked;

  function new();
    foreach (dir_words[d, c]) dir_words[d][c] = '0;
    foreach (shift_words[d]) shift_words[d] = '0;
    dims_reg       = 4'd1;
    bits_reg       = 6'd32;
    gray_reg       = 1'b0;
    msb_reg        = 1'b1;
    shift_reg      = 1'b0;
    mismatches     = 0;
    points         = 0;
    coords_checked = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      spg_pkg::CFG_DIMS_IN_USE:  dims_reg  = data[3:0];
      spg_pkg::CFG_BITS_IN_USE:  bits_reg  = data[5:0];
      spg_pkg::CFG_GRAY_ORDER:   gray_reg  = data[0];
      spg_pkg::CFG_MSB_FIRST:    msb_reg   = data[0];
      spg_pkg::CFG_SHIFT_ENABLE: shift_reg = data[0];
      default: ;
    endcase
  endfunction

  function void note_request(spg_request_t rq);
    int unsigned nd;
    int unsigned nb;
    int unsigned d;
    int unsigned m;
    logic [31:0] idx;
    logic [31:0] acc;
    logic [31:0] rev;
    spg_coord_t  c;
    case (rq.mode)
      spg_pkg::MODE_LOAD_DIR:   dir_words[rq.dim][rq.bit_index] = rq.load_value;
      spg_pkg::MODE_LOAD_SHIFT: shift_words[rq.dim] = rq.load_value;
      spg_pkg::MODE_GEN: begin
        nd = (dims_reg == 0) ? 1 : (dims_reg > SPG_DIMS) ? SPG_DIMS : dims_reg;
        nb = (bits_reg == 0) ? 1 : (bits_reg > SPG_COLS) ? SPG_COLS : bits_reg;
        idx = gray_reg ? (rq.point_index ^ (rq.point_index >> 1)) : rq.point_index;
        points++;
        for (d = 0; d < nd; d++) begin
          acc = '0;
          for (m = 0; m < nb; m++) begin
            if (idx[m]) acc ^= dir_words[d][m];
          end
          // LSB-first table: mirror the sum over the bits in use
          if (!msb_reg) begin
            rev = '0;
            for (m = 0; m < nb; m++) rev[nb-1-m] = acc[m];
            acc = rev;
          end
          if (shift_reg) acc ^= shift_words[d];
          c.out_dim    = 3'(d);
          c.coordinate = acc;
          c.last       = (d + 1 == nd);
          pending_coords.push_back(c);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_coord(spg_coord_t got);
    spg_coord_t exp_c;
    if (pending_coords.size() == 0) begin
      $error("unexpected coordinate: out_dim %0d, coordinate 0x%08h, last %0d",
             got.out_dim, got.coordinate, got.last);
      mismatches++;
      return;
    end
    exp_c = pending_coords.pop_front();
    coords_checked++;
    if (got.out_dim !== exp_c.out_dim) begin
      $error("out_dim mismatch: expected %0d, actual %0d", exp_c.out_dim, got.out_dim);
      mismatches++;
    end
    if (got.coordinate !== exp_c.coordinate) begin
      $error("coordinate mismatch: expected 0x%08h, actual 0x%08h",
             exp_c.coordinate, got.coordinate);
      mismatches++;
    end
    if (got.last !== exp_c.last) begin
      $error("last mismatch: expected %0d, actual %0d", exp_c.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module sobol_point_generator_core_test;
  import spg_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned NUM_PHASES       = 10;
  localparam int unsigned RANDOM_PER_PHASE = 2;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned HOLD_AT          = 20;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned IDLE_LIMIT       = 4000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spg_in_if  in_ch ();
  spg_out_if out_ch ();
  spg_cfg_if cfg_ch ();

  sobol_point_generator_core #(
    .MAX_DIMS(SPG_DIMS),
    .MAX_BITS(SPG_COLS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  sobol_tracker tracker = new();

  int unsigned requests_sent = 0;
  int unsigned settings_used = 1;
  int unsigned send_calm     = 0;
  int unsigned recv_calm     = 0;
  int unsigned idle_cycles   = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int unsigned idle_gap(ref int unsigned calm_left);
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic spg_request_t gen_req(logic [31:0] idx);
    spg_request_t rq;
    rq.mode        = MODE_GEN;
    rq.dim         = 3'($urandom);
    rq.bit_index   = 5'($urandom);
    rq.load_value  = $urandom;
    rq.point_index = idx;
    return rq;
  endfunction

  function automatic spg_request_t load_req(logic [1:0] mode, logic [2:0] dim,
                                            logic [4:0] col, logic [31:0] value);
    spg_request_t rq;
    rq.mode        = mode;
    rq.dim         = dim;
    rq.bit_index   = col;
    rq.load_value  = value;
    rq.point_index = $urandom;
    return rq;
  endfunction

  function automatic logic [31:0] edge_index();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return ~(32'h1 << $urandom_range(0, 31));
    endcase
  endfunction

  function automatic spg_setting_t phase_setting(int unsigned p);
    spg_setting_t s;
    case (p)
      1:       s = '{4'd8, 6'd32, 1'b0, 1'b1, 1'b1};
      2:       s = '{4'd8, 6'd32, 1'b1, 1'b0, 1'b1};
      3:       s = '{4'd1, 6'd1, 1'b0, 1'b0, 1'b1};
      4:       s = '{4'd0, 6'd0, 1'b1, 1'b1, 1'b0};
      5:       s = '{4'd15, 6'd63, 1'b0, 1'b0, 1'b0};
      default: begin
        s.dims  = 4'($urandom_range(0, 15));
        s.bits  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 12));
        s.gray  = 1'($urandom);
        s.msb   = 1'($urandom);
        s.shift = 1'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic send(input spg_request_t rq);
    int unsigned n;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= rq.mode;
    in_ch.dim         <= rq.dim;
    in_ch.bit_index   <= rq.bit_index;
    in_ch.load_value  <= rq.load_value;
    in_ch.point_index <= rq.point_index;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_request(rq);
    requests_sent++;
    n = idle_gap(send_calm);
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending_coords.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input spg_setting_t s);
    int unsigned i;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    for (i = 0; i < 5; i++) begin
      case (i)
        0:       begin idx = CFG_DIMS_IN_USE;  data = 32'(s.dims);  end
        1:       begin idx = CFG_BITS_IN_USE;  data = 32'(s.bits);  end
        2:       begin idx = CFG_GRAY_ORDER;   data = 32'(s.gray);  end
        3:       begin idx = CFG_MSB_FIRST;    data = 32'(s.msb);   end
        default: begin idx = CFG_SHIFT_ENABLE; data = 32'(s.shift); end
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= data;
      do @(posedge clk_i); while (!cfg_ch.ready);
      tracker.set_reg(idx, data);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic fill_directions();
    int unsigned d;
    int unsigned c;
    for (d = 0; d < SPG_DIMS; d++) begin
      for (c = 0; c < SPG_COLS; c++) begin
        send(load_req(MODE_LOAD_DIR, 3'(d), 5'(c), $urandom));
      end
    end
  endtask

  task automatic run_directed(input int unsigned p);
    case (p)
      0: begin
        send(gen_req(32'h0000_0000));
        send(gen_req(32'hFFFF_FFFF));
        send(load_req(MODE_UNUSED, 3'h7, 5'h1F, 32'hFFFF_FFFF));
        send(gen_req(32'h0000_0001));
      end
      1: begin
        // top index bit alone, then loads at the first and last dimension and column
        send(gen_req(32'h8000_0000));
        send(load_req(MODE_LOAD_SHIFT, 3'd0, 5'd0, 32'hFFFF_FFFF));
        send(load_req(MODE_LOAD_SHIFT, 3'd7, 5'd31, 32'hA5A5_5A5A));
        send(load_req(MODE_LOAD_DIR, 3'd7, 5'd31, 32'hFFFF_FFFF));
        send(load_req(MODE_LOAD_DIR, 3'd0, 5'd0, 32'h0000_0000));
        send(gen_req(32'hFFFF_FFFF));
        send(gen_req(32'h5555_5555));
      end
      2: begin
        send(gen_req(32'hAAAA_AAAA));
        send(gen_req(32'hFFFF_FFFF));
        send(gen_req(32'h0000_0000));
      end
      3: begin
        send(gen_req(32'h0000_0001));
        send(gen_req(32'hFFFF_FFFE));
      end
      4: begin
        send(gen_req(32'h0000_0003));
        send(gen_req(32'hFFFF_FFFF));
      end
      5: begin
        send(gen_req(32'hFFFF_FFFF));
        send(gen_req(32'h1234_5678));
      end
      default: ;
    endcase
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned counted;
    int unsigned r;
    int unsigned k;
    counted = 0;
    while (counted < quota) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // table update burst followed by points that use it
        k = $urandom_range(0, 3);
        repeat (k) send(load_req(MODE_LOAD_DIR, 3'($urandom), 5'($urandom), $urandom));
        counted += k;
        if ($urandom_range(0, 2) == 0) begin
          send(load_req(MODE_LOAD_SHIFT, 3'($urandom), 5'($urandom), $urandom));
          counted++;
        end
        k = $urandom_range(1, 3);
        repeat (k) send(gen_req($urandom));
        counted += k;
      end else if (r < 80) begin
        send(gen_req(edge_index()));
        counted++;
      end else if (r < 93) begin
        send(load_req($urandom_range(0, 1) ? MODE_LOAD_DIR : MODE_LOAD_SHIFT,
                      3'($urandom), 5'($urandom), $urandom));
        counted++;
      end else if (r < 97) begin
        send(load_req(MODE_UNUSED, 3'($urandom), 5'($urandom), $urandom));
      end else begin
        stop_sending();
        drain();
      end
    end
  endtask

  initial begin
    int unsigned p;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD_DIR;
    in_ch.dim         <= '0;
    in_ch.bit_index   <= '0;
    in_ch.load_value  <= '0;
    in_ch.point_index <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_DIMS_IN_USE;
    cfg_ch.data       <= '0;
    out_ch.ready      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_directions();
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        stop_sending();
        drain();
        apply_setting(phase_setting(p));
      end
      run_directed(p);
      run_random(RANDOM_PER_PHASE);
    end
    stop_sending();
    drain();
    if (tracker.pending_coords.size() != 0) begin
      $error("%0d coordinates never arrived", tracker.pending_coords.size());
      tracker.mismatches += tracker.pending_coords.size();
    end
    $display("Covered %0d request transfers, %0d points, %0d coordinates checked",
             requests_sent, tracker.points, tracker.coords_checked);
    $display("over %0d register settings, %0d mismatches",
             settings_used, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    int unsigned n;
    int unsigned seen;
    spg_coord_t  got;
    seen = 0;
    n    = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got.out_dim    = out_ch.out_dim;
      got.coordinate = out_ch.coordinate;
      got.last       = out_ch.last;
      tracker.check_coord(got);
      seen++;
      n = (seen == HOLD_AT) ? HOLD_CYCLES : idle_gap(recv_calm);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
